@@ src/hcbp_pkg.sv @@
package hcbp_pkg;

	// Field widths of the item formats.
	localparam int ACT_W   = 2;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int PEND_W  = 7;
	localparam int BCNT_W  = 3;

	// Accumulator holds up to seven pending bits plus one full code.
	localparam int ACC_W   = PEND_W + CODE_W;
	localparam int TOT_W   = 6;

	// Longest code the encoder honors; longer loads are clamped.
	localparam int MAX_CODE_LEN = 32;
	localparam int LEN_LIMIT_I  = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_I);

	// Default size of the code table.
	localparam int DEF_SYMBOL_COUNT = 256;

	// Action codes of an input transaction.
	localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_len;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_byte;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ram_we;
		logic ram_re;
		logic lookup_load;
		logic lookup_commit;
		logic flush_load;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sym_ok;
		logic pend_nonzero;
		logic len_zero;
		logic fits;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

@@ src/huffman_code_bit_packer_core.sv @@
// Table-driven Huffman encoder with an LSB-first byte packer.
// Input channel (in_valid/in_ready/in_data) carries load, encode and flush
// transactions; output channel (out_valid/out_ready/out_data) carries packed
// bytes, with last_byte set on the final byte caused by one input transaction.
// A load writes the code store in its accept cycle and frees the input at once.
// An encode reads the code store (registered read), then emits one byte per
// cycle from the bit accumulator while the output register is free, up to four
// bytes, or none when the code leaves less than a full byte. A flush with bits
// pending emits one byte; otherwise it completes in its accept cycle.
// The first output byte follows the code-store read, the lookup state and the emit state.
// One transaction is processed at a time; the single code-store port and the
// byte-wide emitter set the pace.
// When the receiver stalls, the output register holds its byte and the
// emitter waits; the input stays blocked until the transaction finishes.
// Reset clears the pending bits and the output valid flag. The code store is
// not cleared: a symbol must be loaded before it is encoded.
module huffman_code_bit_packer_core #(
	parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hcbp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbp_pkg::out_item_t out_data
);
	import hcbp_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer for load, lookup and byte emission.
	hcbp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (in_data.action),
		.stat    (stat),
		.in_ready(in_ready),
		.cmd     (cmd)
	);

	// Code store, bit accumulator and output register.
	hcbp_dp #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data),
		.stat     (stat)
	);

endmodule

@@ src/hcbp_ram.sv @@
module hcbp_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/hcbp_ctrl.sv @@
module hcbp_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [hcbp_pkg::ACT_W-1:0] action,
	input  hcbp_pkg::stat_t           stat,
	output logic                      in_ready,
	output hcbp_pkg::cmd_t            cmd
);
	import hcbp_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_LOAD) begin
						cmd.ram_we = stat.sym_ok;
					end else if (action == ACT_ENCODE) begin
						if (stat.sym_ok) begin
							cmd.ram_re = 1'b1;
							state_next = ST_LOOKUP;
						end
					end else if (action == ACT_FLUSH) begin
						if (stat.pend_nonzero) begin
							cmd.flush_load = 1'b1;
							state_next     = ST_EMIT;
						end
					end
				end
			end
			ST_LOOKUP: begin
				// A zero-length code leaves the packer untouched.
				if (stat.len_zero) begin
					state_next = ST_IDLE;
				end else if (stat.fits) begin
					cmd.lookup_commit = 1'b1;
					state_next        = ST_IDLE;
				end else begin
					cmd.lookup_load = 1'b1;
					state_next      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.emit_last) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	// A lookup always leaves the lookup state in the next cycle.
	a_lookup_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOOKUP |=> state_q != ST_LOOKUP)
		else $error("lookup state held for more than one cycle");

	// A blocked output keeps the emitter waiting.
	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !stat.out_free) |=> state_q == ST_EMIT)
		else $error("emitter left while output register was full");
`endif

endmodule

@@ src/hcbp_dp.sv @@
module hcbp_dp #(
	parameter int SYMBOL_COUNT = hcbp_pkg::DEF_SYMBOL_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbp_pkg::in_item_t  in_data,
	input  hcbp_pkg::cmd_t      cmd,
	input  logic                out_ready,
	output logic                out_valid,
	output hcbp_pkg::out_item_t out_data,
	output hcbp_pkg::stat_t     stat
);
	import hcbp_pkg::*;

	localparam int ADDR_W = $clog2(SYMBOL_COUNT);
	localparam int RAM_W  = LEN_W + CODE_W;
	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
	localparam logic [TOT_W-1:0] BYTE_BITS = TOT_W'(BYTE_W);
	localparam logic [TOT_W-1:0] TWO_BYTES = TOT_W'(2 * BYTE_W);

	logic [RAM_W-1:0]  ram_wdata;
	logic [RAM_W-1:0]  ram_rdata;
	logic [LEN_W-1:0]  len_clamped;
	logic [LEN_W-1:0]  rd_len;
	logic [CODE_W-1:0] rd_code;
	logic [CODE_W:0]   len_mask;
	logic [ACC_W-1:0]  code_ext;
	logic [ACC_W-1:0]  acc_lk;
	logic [TOT_W-1:0]  total_lk;

	logic [ACC_W-1:0]  acc_q;
	logic [TOT_W-1:0]  total_q;
	logic [PEND_W-1:0] pending_q;
	logic [BCNT_W-1:0] bit_count_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// Code store: length and code bits side by side in one entry.
	assign len_clamped = (in_data.code_len > LEN_LIMIT) ? LEN_LIMIT : in_data.code_len;
	assign ram_wdata   = {len_clamped, in_data.code_bits};

	hcbp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(SYMBOL_COUNT)
	) u_code_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.re   (cmd.ram_re),
		.addr (in_data.symbol[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Mask the looked-up code and merge it above the pending bits.
	assign rd_len   = ram_rdata[RAM_W-1:CODE_W];
	assign rd_code  = ram_rdata[CODE_W-1:0];
	assign len_mask = ((CODE_W + 1)'(1) << rd_len) - (CODE_W + 1)'(1);
	assign code_ext = {{PEND_W{1'b0}}, rd_code & len_mask[CODE_W-1:0]};
	assign acc_lk   = {{CODE_W{1'b0}}, pending_q} | (code_ext << bit_count_q);
	assign total_lk = {{(TOT_W - BCNT_W){1'b0}}, bit_count_q} + rd_len;

	// Status toward the controller.
	always_comb begin
		stat.sym_ok       = {1'b0, in_data.symbol} < SYM_LIMIT;
		stat.pend_nonzero = bit_count_q != '0;
		stat.len_zero     = rd_len == '0;
		stat.fits         = total_lk < BYTE_BITS;
		stat.emit_last    = total_q < TWO_BYTES;
		stat.out_free     = !out_valid_q || out_ready;
	end

	// Bit accumulator and its fill count.
	always_ff @(posedge clk) begin
		if (cmd.lookup_load) begin
			acc_q   <= acc_lk;
			total_q <= total_lk;
		end else if (cmd.flush_load) begin
			acc_q   <= {{CODE_W{1'b0}}, pending_q};
			total_q <= BYTE_BITS;
		end else if (cmd.emit) begin
			acc_q   <= acc_q >> BYTE_W;
			total_q <= total_q - BYTE_BITS;
		end
	end

	// Pending partial byte, kept between transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			bit_count_q <= '0;
		end else if (cmd.lookup_commit) begin
			pending_q   <= acc_lk[PEND_W-1:0];
			bit_count_q <= total_lk[BCNT_W-1:0];
		end else if (cmd.emit && stat.emit_last) begin
			pending_q   <= acc_q[BYTE_W+PEND_W-1:BYTE_W];
			bit_count_q <= total_q[BCNT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.out_byte  <= acc_q[BYTE_W-1:0];
			out_q.last_byte <= stat.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// Pending bits above the bit count are always clear.
	a_pending_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q >> bit_count_q) == '0)
		else $error("stray bits above the pending count");

	// A byte is only emitted from a full byte of accumulated bits.
	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> total_q >= BYTE_BITS)
		else $error("emit with fewer than eight accumulated bits");

	// The accumulator holds no bits beyond its fill count.
	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (acc_q >> total_q) == '0)
		else $error("stray bits above the accumulator count");
`endif

endmodule

@@ sim/tb_huffman_code_bit_packer_core.sv @@
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer_core;
	import hcbp_pkg::*;

	// Table size of the instance under test and the unused action code.
	localparam int TABLE_SIZE = DEF_SYMBOL_COUNT;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	// Run shape: random item count, pressure points and tail without idling.
	localparam int RANDOM_ITEMS = 410;
	localparam int FIRST_DRAIN = 24;
	localparam int SECOND_DRAIN = 260;
	localparam int LONG_HOLD_AT = 120;
	localparam int LONG_HOLD_CYCLES = 90;
	localparam int QUIET_TAIL = 60;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// Stimulus and expected byte stream.
	in_item_t pending_items[$];
	out_item_t expected_bytes[$];
	int drain_points[$];
	byte unsigned loaded_syms[$];
	bit sym_loaded[TABLE_SIZE];

	// Predicted encoder state.
	logic [CODE_W-1:0] code_table[TABLE_SIZE];
	logic [LEN_W-1:0] len_table[TABLE_SIZE];
	logic [PEND_W-1:0] pend_bits = '0;
	logic [BCNT_W-1:0] pend_count = '0;

	// Handshake bookkeeping and idling control.
	bit in_taken = 1'b0;
	int accepted_count = 0;
	int issued_count = 0;
	int total_items = 0;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	huffman_code_bit_packer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Works out the bytes that one accepted transaction produces.
	function automatic void predict_packer(input in_item_t item);
		logic [63:0] acc;
		int total;
		int clen;
		out_item_t res;
		case (item.action)
			ACT_LOAD: begin
				if (int'(item.symbol) < TABLE_SIZE) begin
					code_table[item.symbol] = item.code_bits;
					len_table[item.symbol] = (item.code_len > LEN_LIMIT) ? LEN_LIMIT
						: item.code_len;
				end
			end
			ACT_ENCODE: begin
				if (int'(item.symbol) < TABLE_SIZE) begin
					clen = int'(len_table[item.symbol]);
					if (clen != 0) begin
						acc = {32'b0, code_table[item.symbol]};
						if (clen < 32)
							acc &= (64'd1 << clen) - 64'd1;
						acc = (acc << pend_count) | {57'b0, pend_bits};
						total = int'(pend_count) + clen;
						while (total >= 8) begin
							res.out_byte = acc[7:0];
							res.last_byte = (total < 16);
							expected_bytes.push_back(res);
							acc >>= 8;
							total -= 8;
						end
						pend_bits = acc[PEND_W-1:0];
						pend_count = total[BCNT_W-1:0];
					end
				end
			end
			ACT_FLUSH: begin
				if (pend_count != 0) begin
					res.out_byte = {1'b0, pend_bits};
					res.last_byte = 1'b1;
					expected_bytes.push_back(res);
				end
				pend_bits = '0;
				pend_count = '0;
			end
			default: begin
			end
		endcase
	endfunction

	// Appends one transaction to the stimulus and tracks which symbols are loaded.
	function automatic void queue_transaction(input logic [ACT_W-1:0] action,
			input logic [SYM_W-1:0] symbol, input logic [CODE_W-1:0] code_bits,
			input logic [LEN_W-1:0] code_len);
		in_item_t item;
		item.action = action;
		item.symbol = symbol;
		item.code_bits = code_bits;
		item.code_len = code_len;
		pending_items.push_back(item);
		if (action == ACT_LOAD && int'(symbol) < TABLE_SIZE && !sym_loaded[symbol]) begin
			sym_loaded[symbol] = 1'b1;
			loaded_syms.push_back(symbol);
		end
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 45;
		endcase
	endfunction

	// Scoreboard: sample both channels at the rising edge.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual out_byte=%02h last_byte=%b",
					$realtime, out_data.out_byte, out_data.last_byte);
				mismatches++;
			end else begin
				want = expected_bytes.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte mismatch: expected %02h actual %02h",
						$realtime, want.out_byte, out_data.out_byte);
					mismatches++;
				end
				if (out_data.last_byte !== want.last_byte) begin
					$display("%0t: last_byte mismatch: expected %b actual %b",
						$realtime, want.last_byte, out_data.last_byte);
					mismatches++;
				end
			end
		end
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			predict_packer(in_data);
			accepted_count++;
		end
	end

	// Input driver: presents the next transaction once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (drain_points.size() != 0 && issued_count == drain_points[0]
					&& expected_bytes.size() != 0) begin
				// Sender pauses here until every predicted byte has come out.
				in_valid <= 1'b0;
			end else if (accepted_count < total_items - QUIET_TAIL
					&& $urandom_range(99) < send_pct) begin
				send_gap = $urandom_range(1, 12) - 1;
				in_valid <= 1'b0;
			end else begin
				if (drain_points.size() != 0 && issued_count == drain_points[0])
					void'(drain_points.pop_front());
				if (issued_count % 40 == 0) begin
					send_pct = pick_idle_pct();
					recv_pct = pick_idle_pct();
				end
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				issued_count++;
			end
		end
	end

	// Output receiver: random stalls plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && accepted_count >= LONG_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else if (accepted_count < total_items - QUIET_TAIL
					&& $urandom_range(99) < recv_pct) begin
				recv_gap = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus build, reset and end of run.
	initial begin
		int r;
		int pick;
		logic [LEN_W-1:0] len;

		// Directed part: empty code, idle flush, unused action, longest codes.
		queue_transaction(ACT_LOAD, 8'd0, 32'hDEAD_BEEF, 6'd0);
		queue_transaction(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
		queue_transaction(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		queue_transaction(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		queue_transaction(ACT_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32);
		queue_transaction(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
		queue_transaction(ACT_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd1);
		for (int i = 0; i < 7; i++)
			queue_transaction(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
		// Seven bits pending plus a full 32-bit code gives four bytes.
		queue_transaction(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
		queue_transaction(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		// Over-long lengths are clamped to the code width.
		queue_transaction(ACT_LOAD, 8'd2, 32'hA5A5_5A5A, 6'd63);
		queue_transaction(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
		queue_transaction(ACT_LOAD, 8'd128, 32'h1234_56C3, 6'd33);
		queue_transaction(ACT_ENCODE, 8'd128, 32'h0, 6'd0);
		// Code bits above the length must be ignored.
		queue_transaction(ACT_LOAD, 8'd4, 32'hFFFF_FFF5, 6'd3);
		queue_transaction(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
		queue_transaction(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		queue_transaction(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
		queue_transaction(ACT_LOAD, 8'd170, 32'h0000_00C3, 6'd8);
		queue_transaction(ACT_ENCODE, 8'd170, 32'h0, 6'd0);

		drain_points.push_back(FIRST_DRAIN);
		drain_points.push_back(SECOND_DRAIN);

		// Random part: mostly encodes of loaded symbols, with loads, flushes and unused actions.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(99);
			if (r < 14) begin
				pick = $urandom_range(99);
				if (pick < 70)
					len = LEN_W'($urandom_range(1, 12));
				else if (pick < 90)
					len = LEN_W'($urandom_range(13, 32));
				else
					len = LEN_W'($urandom_range(0, 63));
				queue_transaction(ACT_LOAD, SYM_W'($urandom), $urandom, len);
			end else if (r < 86) begin
				pick = $urandom_range(loaded_syms.size() - 1);
				queue_transaction(ACT_ENCODE, loaded_syms[pick], $urandom,
					LEN_W'($urandom));
			end else if (r < 96) begin
				queue_transaction(ACT_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
			end else begin
				queue_transaction(ACT_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
			end
		end
		total_items = pending_items.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
